// File: hw/rtl/rct_pkg.sv
package rct_pkg;

  // Request phase, also reported on the result channel
  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_ISSUED   = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [3:0] {
    ST_ACCEPTED      = 4'd0,
    ST_OTHER_USER    = 4'd1,
    ST_OTHER_REQUEST = 4'd2,
    ST_AFTER_FINISH  = 4'd3,
    ST_DUPLICATE     = 4'd4,
    ST_TIMED_OUT     = 4'd5,
    ST_NO_REQUEST    = 4'd6,
    ST_ISSUED        = 4'd7,
    ST_NONE_EXPECTED = 4'd8,
    ST_BUSY          = 4'd9,
    ST_TOO_MANY      = 4'd10,
    ST_TICK          = 4'd11,
    ST_TICK_TIMEOUT  = 4'd12,
    ST_READ          = 4'd13
  } status_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_LOCAL_USER = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } cfg_idx_e;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned TICK_W    = 21;
  localparam int unsigned WANT_W    = 8;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [TICK_W-1:0]    TICK_MAX      = 21'h1FFFFF;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd50000;

  // Store request from the control logic into the cell row
  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] user;
    logic [DATA_W-1:0] value;
  } wr_t;

  // Read-back of one stored reply
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] user;
    logic [DATA_W-1:0] value;
  } rd_t;

endpackage

// File: hw/rtl/rct_cell.sv
module rct_cell
  import rct_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [DATA_W-1:0] wr_user_i,
  input  logic [DATA_W-1:0] wr_value_i,
  input  logic              live_i,
  input  logic [DATA_W-1:0] probe_i,
  input  logic              hit_i,
  output logic [DATA_W-1:0] probe_o,
  output logic              hit_o,
  output logic [DATA_W-1:0] user_o,
  output logic [DATA_W-1:0] value_o
);

  logic [DATA_W-1:0] user_q;
  logic [DATA_W-1:0] value_q;

  // Capture one reply; contents are meaningful only while live
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      user_q  <= wr_user_i;
      value_q <= wr_value_i;
    end
  end

  // Pass the probed responder on and fold in this cell's match
  assign probe_o = probe_i;
  assign hit_o   = hit_i | (live_i & (user_q == probe_i));
  assign user_o  = user_q;
  assign value_o = value_q;

endmodule

// File: hw/rtl/rct_chain.sv
module rct_chain
  import rct_pkg::*;
#(
  parameter int unsigned MAX_RESPONDERS = 16,
  parameter int unsigned CW             = 5
) (
  input  logic             clk_i,
  input  wr_t              wr_i,
  input  logic [CW-1:0]    stored_i,
  input  logic [DATA_W-1:0] probe_i,
  input  logic [IDX_W-1:0] rd_index_i,
  output logic             dup_o,
  output rd_t              rd_o
);

  localparam int unsigned RD_N  = (MAX_RESPONDERS < 16) ? MAX_RESPONDERS : 16;
  localparam int unsigned CMP_W = (CW > IDX_W) ? CW + 1 : IDX_W + 1;

  logic [DATA_W-1:0] probe_w [MAX_RESPONDERS+1];
  logic              hit_w   [MAX_RESPONDERS+1];
  logic [DATA_W-1:0] user_w  [MAX_RESPONDERS];
  logic [DATA_W-1:0] value_w [MAX_RESPONDERS];

  assign probe_w[0] = probe_i;
  assign hit_w[0]   = 1'b0;

  // Row of cells, one per stored reply slot
  for (genvar k = 0; k < MAX_RESPONDERS; k++) begin : g_cell
    logic live;
    logic wr_en;
    assign live  = (CW'(k) < stored_i);
    assign wr_en = wr_i.en && (stored_i == CW'(k));

    rct_cell u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (wr_en),
      .wr_user_i  (wr_i.user),
      .wr_value_i (wr_i.value),
      .live_i     (live),
      .probe_i    (probe_w[k]),
      .hit_i      (hit_w[k]),
      .probe_o    (probe_w[k+1]),
      .hit_o      (hit_w[k+1]),
      .user_o     (user_w[k]),
      .value_o    (value_w[k])
    );
  end

  assign dup_o = hit_w[MAX_RESPONDERS];

  // Select the addressed slot; zero unless below the stored count
  always_comb begin
    logic sel_valid;
    sel_valid = (CMP_W'(rd_index_i) < CMP_W'(stored_i)) &&
                (CMP_W'(rd_index_i) < CMP_W'(MAX_RESPONDERS));
    rd_o = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (sel_valid && (rd_index_i == IDX_W'(k))) begin
        rd_o.valid = 1'b1;
        rd_o.user  = user_w[k];
        rd_o.value = value_w[k];
      end
    end
  end

endmodule

// File: hw/rtl/response_collection_tracker_core.sv
// Response collection tracker. Follows one outstanding broadcast request:
// a start request opens it with an expected reply count (at most
// MAX_RESPONDERS), replies addressed to local_user_id and the active
// request id are stored in a row of cells that also compares every stored
// responder id against an incoming reply to catch duplicates, one-millisecond
// ticks run the timeout, and read requests return a stored reply. Every
// request gives exactly one result, registered at the output; one request
// is taken per cycle while the result side keeps up, since the duplicate
// compare across the cell row and the next-state logic are combinational.
// Write configuration only while the block is idle.
module response_collection_tracker_core
  import rct_pkg::*;
#(
  parameter int unsigned MAX_RESPONDERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [WANT_W-1:0]    participants_i,
  input  logic [DATA_W-1:0]    target_user_i,
  input  logic [DATA_W-1:0]    reply_request_id_i,
  input  logic [DATA_W-1:0]    responder_id_i,
  input  logic [DATA_W-1:0]    reply_value_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           status_o,
  output logic [1:0]           phase_o,
  output logic [DATA_W-1:0]    current_request_id_o,
  output logic [CNT_OUT_W-1:0] received_count_o,
  output logic                 entry_valid_o,
  output logic [DATA_W-1:0]    entry_user_o,
  output logic [DATA_W-1:0]    entry_value_o
);

  localparam int unsigned CW    = $clog2(MAX_RESPONDERS + 1);
  localparam int unsigned CMP_W = (CW > WANT_W) ? CW + 1 : WANT_W + 1;

  logic [DATA_W-1:0]    local_user_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  phase_e            phase_q, phase_d;
  logic [DATA_W-1:0] active_id_q, active_id_d;
  logic [DATA_W-1:0] next_id_q, next_id_d;
  logic [CW-1:0]     expected_q, expected_d;
  logic [CW-1:0]     stored_q, stored_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  phase_e               out_phase_q;
  logic [DATA_W-1:0]    out_id_q;
  logic [CNT_OUT_W-1:0] out_count_q;
  rd_t                  out_rd_q, out_rd_d;

  kind_e             kind;
  logic              accept;
  logic              dup;
  rd_t               rd;
  wr_t               wr;
  logic              timed;
  logic              rep_pass;
  logic              full;
  logic [CW-1:0]     stored_inc;
  logic [TICK_W-1:0] tick_el;
  logic              tick_to;
  logic              want_ok;

  assign kind        = kind_e'(kind_i);
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_user_q <= '0;
      timeout_q    <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOCAL_USER: local_user_q <= cfg_data_i;
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TIMEOUT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Shared conditions of the request checks
  assign timed      = (phase_q == PH_ISSUED) && (elapsed_q > TICK_W'(timeout_q));
  assign rep_pass   = !timed && (target_user_i == local_user_q) &&
                      (reply_request_id_i == active_id_q) &&
                      (phase_q == PH_ISSUED) && !dup;
  assign full       = (stored_q >= CW'(MAX_RESPONDERS));
  assign stored_inc = stored_q + CW'(1);
  assign tick_el    = (elapsed_q == TICK_MAX) ? elapsed_q : elapsed_q + TICK_W'(1);
  assign tick_to    = (tick_el > TICK_W'(timeout_q));
  assign want_ok    = (participants_i != '0) &&
                      (CMP_W'(participants_i) <= CMP_W'(MAX_RESPONDERS));

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (kind)
        KIND_START: begin
          if (phase_q != PH_ISSUED) begin
            if (participants_i == '0) begin
              phase_d = PH_FINISHED;
            end else if (want_ok) begin
              phase_d = PH_ISSUED;
            end
          end
        end
        KIND_REPLY: begin
          if (timed) begin
            phase_d = PH_FINISHED;
          end else if (rep_pass && (full || stored_inc == expected_q)) begin
            phase_d = PH_FINISHED;
          end
        end
        KIND_TICK: begin
          if (phase_q == PH_ISSUED && tick_to) begin
            phase_d = PH_FINISHED;
          end
        end
        default: ;
      endcase
    end
  end

  // Status, counters and store request
  always_comb begin
    status_d    = ST_READ;
    active_id_d = active_id_q;
    next_id_d   = next_id_q;
    expected_d  = expected_q;
    stored_d    = stored_q;
    elapsed_d   = elapsed_q;
    out_rd_d    = '0;
    wr.en       = 1'b0;
    wr.user     = responder_id_i;
    wr.value    = reply_value_i;
    unique case (kind)
      KIND_START: begin
        if (phase_q == PH_ISSUED) begin
          status_d = ST_BUSY;
        end else if (participants_i == '0) begin
          status_d = ST_NONE_EXPECTED;
        end else if (!want_ok) begin
          status_d = ST_TOO_MANY;
        end else begin
          status_d    = ST_ISSUED;
          expected_d  = CW'(participants_i);
          stored_d    = '0;
          elapsed_d   = '0;
          active_id_d = next_id_q;
          next_id_d   = next_id_q + DATA_W'(1);
        end
      end
      KIND_REPLY: begin
        if (timed) begin
          status_d = ST_TIMED_OUT;
        end else if (target_user_i != local_user_q) begin
          status_d = ST_OTHER_USER;
        end else if (reply_request_id_i != active_id_q) begin
          status_d = ST_OTHER_REQUEST;
        end else if (phase_q == PH_NONE) begin
          status_d = ST_NO_REQUEST;
        end else if (phase_q != PH_ISSUED) begin
          status_d = ST_AFTER_FINISH;
        end else if (dup) begin
          status_d = ST_DUPLICATE;
        end else if (full) begin
          status_d = ST_AFTER_FINISH;
        end else begin
          status_d = ST_ACCEPTED;
          stored_d = stored_inc;
          wr.en    = accept;
        end
      end
      KIND_TICK: begin
        if (phase_q == PH_ISSUED) begin
          elapsed_d = tick_el;
          status_d  = tick_to ? ST_TICK_TIMEOUT : ST_TICK;
        end else begin
          status_d = ST_TICK;
        end
      end
      KIND_READ: begin
        status_d = ST_READ;
        out_rd_d = rd;
      end
      default: ;
    endcase
  end

  // Reply store with duplicate search and read-back
  rct_chain #(
    .MAX_RESPONDERS (MAX_RESPONDERS),
    .CW             (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .stored_i   (stored_q),
    .probe_i    (responder_id_i),
    .rd_index_i (entry_index_i),
    .dup_o      (dup),
    .rd_o       (rd)
  );

  // Request state, advanced on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NONE;
      active_id_q <= '0;
      next_id_q   <= '0;
      expected_q  <= '0;
      stored_q    <= '0;
      elapsed_q   <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      active_id_q <= active_id_d;
      next_id_q   <= next_id_d;
      expected_q  <= expected_d;
      stored_q    <= stored_d;
      elapsed_q   <= elapsed_d;
    end
  end

  // Result register: hold while stalled, load on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_phase_q <= phase_d;
      out_id_q    <= active_id_d;
      out_count_q <= CNT_OUT_W'(stored_d);
      out_rd_q    <= out_rd_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign phase_o              = out_phase_q;
  assign current_request_id_o = out_id_q;
  assign received_count_o     = out_count_q;
  assign entry_valid_o        = out_rd_q.valid;
  assign entry_user_o         = out_rd_q.user;
  assign entry_value_o        = out_rd_q.value;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= expected_q)
    else $error("stored reply count exceeds expected count");

  a_issued_expects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ISSUED) |-> (expected_q != '0))
    else $error("issued request expects no replies");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_entry_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rd_q.valid) |-> (status_q == ST_READ))
    else $error("entry data on a result that is not a read");

endmodule

// File: tb/tb_response_collection_tracker_core.sv
module tb_response_collection_tracker_core;
  import rct_pkg::*;

  localparam int unsigned MAX_RESPONDERS = 16;
  localparam logic [7:0]  CAP_WANT       = 8'(MAX_RESPONDERS);
  localparam logic [4:0]  CAP_STORED     = 5'(MAX_RESPONDERS);
  localparam int          POOL_SIZE      = 20;
  localparam int          PHASE_ITEMS    = 150;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          QUIET_LIMIT    = 2000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH,
    IDLE_PRESSURE
  } idle_mode_e;

  // One request on the input channel; fill_id takes the live request id at launch
  typedef struct {
    kind_e       kind;
    logic [7:0]  want;
    logic [31:0] target;
    logic [31:0] rid;
    logic [31:0] who;
    logic [31:0] val;
    logic [3:0]  idx;
    bit          fill_id;
  } request_t;

  // One result on the output channel
  typedef struct {
    status_e     status;
    phase_e      phase;
    logic [31:0] req_id;
    logic [4:0]  stored;
    logic        valid;
    logic [31:0] user;
    logic [31:0] value;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index = CFG_LOCAL_USER;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  kind_e       kind = KIND_START;
  logic [7:0]  participants = '0;
  logic [31:0] target_user = '0;
  logic [31:0] reply_rid = '0;
  logic [31:0] responder = '0;
  logic [31:0] reply_val = '0;
  logic [3:0]  entry_idx = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [3:0]  status_o;
  logic [1:0]  phase_o;
  logic [31:0] current_request_id_o;
  logic [4:0]  received_count_o;
  logic        entry_valid_o;
  logic [31:0] entry_user_o;
  logic [31:0] entry_value_o;

  // Tracker shadow state and configuration
  phase_e      trk_phase = PH_NONE;
  logic [31:0] trk_active_id = '0;
  logic [31:0] trk_next_id = '0;
  logic [4:0]  trk_want = '0;
  logic [4:0]  trk_got = '0;
  logic [20:0] trk_ticks = '0;
  logic [31:0] trk_who [MAX_RESPONDERS];
  logic [31:0] trk_val [MAX_RESPONDERS];
  logic [31:0] cfg_user = '0;
  logic [19:0] cfg_timeout = TIMEOUT_RESET;

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  request_t    cur_req;
  outcome_t    head;
  bit          in_flight = 1'b0;
  idle_mode_e  idle_mode = IDLE_NONE;
  logic [31:0] resp_pool [POOL_SIZE];
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  int          mismatch_cnt = 0;
  int          result_cnt = 0;

  response_collection_tracker_core #(
    .MAX_RESPONDERS(MAX_RESPONDERS)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind),
    .participants_i      (participants),
    .target_user_i       (target_user),
    .reply_request_id_i  (reply_rid),
    .responder_id_i      (responder),
    .reply_value_i       (reply_val),
    .entry_index_i       (entry_idx),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .status_o            (status_o),
    .phase_o             (phase_o),
    .current_request_id_o(current_request_id_o),
    .received_count_o    (received_count_o),
    .entry_valid_o       (entry_valid_o),
    .entry_user_o        (entry_user_o),
    .entry_value_o       (entry_value_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic request_t make_request(kind_e k, logic [7:0] want, logic [31:0] target,
                                            logic [31:0] rid, logic [31:0] who,
                                            logic [31:0] val, logic [3:0] idx, bit fill);
    request_t r;
    r.kind = k;
    r.want = want;
    r.target = target;
    r.rid = rid;
    r.who = who;
    r.val = val;
    r.idx = idx;
    r.fill_id = fill;
    return r;
  endfunction

  // Append a request to the pending list
  function automatic void add_request(request_t r);
    request_q.insert(request_q.size(), r);
  endfunction

  // Advance the tracker by one request and return the result it gives
  function automatic outcome_t tracker_outcome(request_t r);
    outcome_t o;
    bit dup;
    o.valid = 1'b0;
    o.user = '0;
    o.value = '0;
    dup = 1'b0;
    case (r.kind)
      KIND_START: begin
        if (trk_phase == PH_ISSUED) begin
          o.status = ST_BUSY;
        end else if (r.want == 8'd0) begin
          trk_phase = PH_FINISHED;
          o.status = ST_NONE_EXPECTED;
        end else if (r.want > CAP_WANT) begin
          o.status = ST_TOO_MANY;
        end else begin
          trk_want = r.want[4:0];
          trk_got = '0;
          trk_ticks = '0;
          trk_active_id = trk_next_id;
          trk_next_id = trk_next_id + 32'd1;
          trk_phase = PH_ISSUED;
          o.status = ST_ISSUED;
        end
      end
      KIND_REPLY: begin
        for (int i = 0; i < MAX_RESPONDERS; i++) begin
          if (5'(i) < trk_got && trk_who[i] == r.who) dup = 1'b1;
        end
        if (trk_phase == PH_ISSUED && trk_ticks > {1'b0, cfg_timeout}) begin
          trk_phase = PH_FINISHED;
          o.status = ST_TIMED_OUT;
        end else if (r.target != cfg_user) begin
          o.status = ST_OTHER_USER;
        end else if (r.rid != trk_active_id) begin
          o.status = ST_OTHER_REQUEST;
        end else if (trk_phase == PH_NONE) begin
          o.status = ST_NO_REQUEST;
        end else if (trk_phase != PH_ISSUED) begin
          o.status = ST_AFTER_FINISH;
        end else if (dup) begin
          o.status = ST_DUPLICATE;
        end else if (trk_got >= CAP_STORED) begin
          trk_phase = PH_FINISHED;
          o.status = ST_AFTER_FINISH;
        end else begin
          trk_who[trk_got[3:0]] = r.who;
          trk_val[trk_got[3:0]] = r.val;
          trk_got = trk_got + 5'd1;
          if (trk_got == trk_want) trk_phase = PH_FINISHED;
          o.status = ST_ACCEPTED;
        end
      end
      KIND_TICK: begin
        o.status = ST_TICK;
        if (trk_phase == PH_ISSUED) begin
          if (trk_ticks != TICK_MAX) trk_ticks = trk_ticks + 21'd1;
          if (trk_ticks > {1'b0, cfg_timeout}) begin
            trk_phase = PH_FINISHED;
            o.status = ST_TICK_TIMEOUT;
          end
        end
      end
      default: begin
        o.status = ST_READ;
        if ({1'b0, r.idx} < trk_got) begin
          o.valid = 1'b1;
          o.user = trk_who[r.idx];
          o.value = trk_val[r.idx];
        end
      end
    endcase
    o.phase = trk_phase;
    o.req_id = trk_active_id;
    o.stored = trk_got;
    return o;
  endfunction

  // Decide whether a side rests this cycle, by the current idling phase
  function automatic bit idle_roll(bit receiver);
    int rate;
    case (idle_mode)
      IDLE_SENDER:   rate = receiver ? 0 : 61;
      IDLE_RECEIVER: rate = receiver ? 61 : 0;
      IDLE_BOTH:     rate = 13;
      default:       rate = 0;
    endcase
    return $urandom_range(99) < rate;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 100)
      $display("mismatch on %s at result %0d: got %h, want %h", field, result_cnt, got, want);
  endtask

  // Input driver: predict each accepted request, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_flight = 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        outcome_q.insert(outcome_q.size(), tracker_outcome(cur_req));
        in_flight = 1'b0;
      end
      if (!in_flight) begin
        if (request_q.size() != 0 && !idle_roll(1'b0)) begin
          cur_req = request_q.pop_front();
          if (cur_req.fill_id) cur_req.rid = trk_active_id;
          in_valid     <= 1'b1;
          kind         <= cur_req.kind;
          participants <= cur_req.want;
          target_user  <= cur_req.target;
          reply_rid    <= cur_req.rid;
          responder    <= cur_req.who;
          reply_val    <= cur_req.val;
          entry_idx    <= cur_req.idx;
          in_flight = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest prediction, then pick the stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result status", 32'(status_o), 32'd0);
        end else begin
          head = outcome_q.pop_front();
          if (status_o !== head.status)
            report_mismatch("status", 32'(status_o), 32'(head.status));
          if (phase_o !== head.phase)
            report_mismatch("phase", 32'(phase_o), 32'(head.phase));
          if (current_request_id_o !== head.req_id)
            report_mismatch("request id", current_request_id_o, head.req_id);
          if (received_count_o !== head.stored)
            report_mismatch("received count", 32'(received_count_o), 32'(head.stored));
          if (entry_valid_o !== head.valid)
            report_mismatch("entry valid", 32'(entry_valid_o), 32'(head.valid));
          if (entry_user_o !== head.user)
            report_mismatch("entry user", entry_user_o, head.user);
          if (entry_value_o !== head.value)
            report_mismatch("entry value", entry_value_o, head.value);
        end
        result_cnt++;
      end
      // hold off once for a long stretch so the block backs up
      if (idle_mode == IDLE_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_roll(1'b1);
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** response_collection_tracker_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (request_q.size() != 0 || in_flight || outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOCAL_USER) cfg_user = data;
    else cfg_timeout = data[19:0];
  endtask

  // Start a request, answer it from the responder pool, then read back
  task automatic queue_sequence();
    int n;
    int extra;
    logic [31:0] who;
    n = ($urandom_range(99) < 12) ? MAX_RESPONDERS : int'($urandom_range(1, 6));
    extra = $urandom_range(2);
    add_request(make_request(KIND_START, 8'(n), '0, '0, '0, '0, '0, 1'b0));
    for (int i = 0; i < n + extra; i++) begin
      if ($urandom_range(99) < 15) begin
        add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
      end else begin
        who = ($urandom_range(99) < 80) ? resp_pool[i % POOL_SIZE]
                                        : resp_pool[$urandom_range(POOL_SIZE - 1)];
        add_request(make_request(KIND_REPLY, '0, cfg_user, '0, who, $urandom,
                                 '0, 1'b1));
      end
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 45))
        add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
    end
    repeat ($urandom_range(1, 3))
      add_request(make_request(KIND_READ, '0, '0, '0, '0, '0,
                               4'($urandom_range(15)), 1'b0));
  endtask

  // Random request of any kind, often aimed slightly off
  task automatic queue_noise();
    logic [31:0] target;
    case ($urandom_range(2))
      0:       target = cfg_user;
      1:       target = cfg_user ^ (32'd1 << $urandom_range(31));
      default: target = $urandom;
    endcase
    add_request(make_request(kind_e'($urandom_range(3)), 8'($urandom_range(255)),
                             target, $urandom,
                             ($urandom_range(1) != 0) ? resp_pool[$urandom_range(19)]
                                                      : $urandom,
                             $urandom, 4'($urandom_range(15)),
                             1'($urandom_range(1))));
  endtask

  initial begin
    logic [19:0] tmo;
    logic [31:0] user;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle behavior, refusals, filters, duplicates, finish, reads
    add_request(make_request(KIND_READ, '0, '0, '0, '0, '0, 4'd0, 1'b0));
    add_request(make_request(KIND_REPLY, '0, '0, '0, 32'd1, 32'd2, '0, 1'b0));
    add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_START, 8'd0, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_START, 8'd17, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_START, 8'd255, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_START, 8'd2, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_START, 8'd0, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_REPLY, '0, '1, '0, 32'd3, 32'd4, '0, 1'b1));
    add_request(make_request(KIND_REPLY, '0, '0, '1, 32'd3, 32'd4, '0, 1'b0));
    add_request(make_request(KIND_REPLY, '0, '0, '0, '0, '1, '0, 1'b1));
    add_request(make_request(KIND_REPLY, '0, '0, '0, '0, 32'd5, '0, 1'b1));
    add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_READ, '0, '0, '0, '0, '0, 4'd0, 1'b0));
    add_request(make_request(KIND_REPLY, '0, '0, '0, '1, '0, '0, 1'b1));
    add_request(make_request(KIND_REPLY, '0, '0, '0, 32'd7, 32'd8, '0, 1'b1));
    add_request(make_request(KIND_READ, '0, '0, '0, '0, '0, 4'd1, 1'b0));
    add_request(make_request(KIND_READ, '0, '0, '0, '0, '0, 4'd15, 1'b0));
    add_request(make_request(KIND_START, 8'd0, '0, '0, '0, '0, '0, 1'b0));
    add_request(make_request(KIND_READ, '0, '0, '0, '0, '0, 4'd1, 1'b0));
    drain();

    // Directed: a full-size request timed out by ticks
    write_reg(CFG_LOCAL_USER, '1);
    write_reg(CFG_TIMEOUT, {12'hABC, 20'd2});
    add_request(make_request(KIND_START, 8'd16, '0, '0, '0, '0, '0, 1'b0));
    repeat (3) add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
    drain();

    // Directed: a reply dropped because the limit was lowered under it
    write_reg(CFG_TIMEOUT, {12'd0, 20'hFFFFF});
    add_request(make_request(KIND_START, 8'd1, '0, '0, '0, '0, '0, 1'b0));
    repeat (2) add_request(make_request(KIND_TICK, '0, '0, '0, '0, '0, '0, 1'b0));
    drain();
    write_reg(CFG_TIMEOUT, 32'd0);
    add_request(make_request(KIND_REPLY, '0, '1, '0, 32'd9, 32'd10, '0, 1'b1));

    // Random phases, each with its own settings and idling pattern
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       user = '0;
        1:       user = '1;
        default: user = $urandom;
      endcase
      case (p)
        0:       tmo = 20'd0;
        1, 4:    tmo = 20'($urandom_range(3, 40));
        2:       tmo = 20'hFFFFF;
        3:       tmo = TIMEOUT_RESET;
        default: tmo = 20'd1;
      endcase
      write_reg(CFG_LOCAL_USER, user);
      write_reg(CFG_TIMEOUT, {12'($urandom), tmo});
      case (p)
        1:       idle_mode = IDLE_SENDER;
        2:       idle_mode = IDLE_RECEIVER;
        3:       idle_mode = IDLE_BOTH;
        4:       idle_mode = IDLE_PRESSURE;
        default: idle_mode = IDLE_NONE;
      endcase
      for (int i = 0; i < POOL_SIZE; i++) resp_pool[i] = $urandom;
      while (request_q.size() < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) queue_sequence();
        else queue_noise();
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("** response_collection_tracker_core: PASSED **");
    end else begin
      $display("** response_collection_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule
